FILE: hw/rtl/sorted_snapshot_cache_with_expiry_core_assert.svh
// assertion macros used by the checker file
`ifndef SORTED_SNAPSHOT_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH
`define SORTED_SNAPSHOT_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define SSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc assertion failed");

// next-cycle implication, masked during reset
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc assertion failed");

// next-cycle implication that also holds across reset
`define SSC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssc assertion failed");

`endif

FILE: hw/rtl/ssc_pkg.sv
// types, codes and defaults for the sorted snapshot cache
package ssc_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam logic [31:0] EXPIRY_RESET = 32'd3600;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REORG  = 2'd2;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_EXPIRED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FOUND   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] stamp;
    logic [31:0] handle;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_key;
    logic [63:0] found_stamp;
    logic [31:0] found_handle;
    logic [4:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] stamp;
    logic [31:0] handle;
  } entry_t;

  // what one cell shows its neighbours
  typedef struct packed {
    entry_t ent;
    logic   valid;
    logic   ahead;
  } link_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE,
    OP_SHIFT,
    OP_TRIM
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t    op;
    entry_t      ent;
    logic        exists;
    logic [63:0] thr;
  } cmd_t;

  // summary of the chain seen by the sequencer
  typedef struct packed {
    entry_t head;
    logic   head_valid;
    logic   any_match;
    logic   any_kill;
  } chain_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_THR,
    S_TRIM,
    S_ROT,
    S_CUT,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/sorted_snapshot_cache_with_expiry_core.sv
// Sorted snapshot cache: one item at a time, result in an output register.
// Steps per item: a rejected add goes from exec to done; a stored add inserts, takes the
// new threshold, then trims one expired entry per step; a lookup of a non-empty chain rotates
// it once past its head; a reorg shifts out one entry per step; an unused kind goes to done.
// The next item is taken in the cycle after the result is loaded.
// Synchronous reset empties the chain, clears the count and sets expiry to 3600.
module sorted_snapshot_cache_with_expiry_core #(
  parameter int CAPACITY = ssc_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  ssc_pkg::cmd_t   cmd;
  ssc_pkg::chain_t chain;
  ssc_pkg::link_t  links [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] kill_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ssc_pkg::link_t prev_l, next_l;
      if (gi == 0) begin : g_first
        // the front behaves as if a larger key stood before it
        assign prev_l.ent   = '0;
        assign prev_l.valid = 1'b0;
        assign prev_l.ahead = 1'b1;
      end else begin : g_mid
        assign prev_l = links[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_l.ent   = '0;
        assign next_l.valid = 1'b0;
        assign next_l.ahead = 1'b0;
      end else begin : g_inner
        assign next_l = links[gi+1];
      end
      ssc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .prev_link (prev_l),
        .next_link (next_l),
        .head_ent  (links[0].ent),
        .link_o    (links[gi]),
        .match_o   (match_vec[gi]),
        .kill_o    (kill_vec[gi])
      );
    end
  endgenerate

  assign chain.head       = links[0].ent;
  assign chain.head_valid = links[0].valid;
  assign chain.any_match  = |match_vec;
  assign chain.any_kill   = |kill_vec;

  ssc_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chain     (chain),
    .cmd       (cmd)
  );

endmodule

FILE: hw/rtl/ssc_cell.sv
// one entry cell of the key-descending chain
module ssc_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  ssc_pkg::cmd_t  cmd,
  input  ssc_pkg::link_t prev_link,
  input  ssc_pkg::link_t next_link,
  input  ssc_pkg::entry_t head_ent,
  output ssc_pkg::link_t link_o,
  output logic           match_o,
  output logic           kill_o
);

  ssc_pkg::entry_t ent_r, ent_nxt;
  logic            valid_r, valid_nxt;
  logic            ahead;

  assign ahead   = valid_r && (ent_r.key > cmd.ent.key);
  assign match_o = valid_r && (ent_r.key == cmd.ent.key);
  // lowest-key valid entry at or below the threshold
  assign kill_o  = valid_r && !next_link.valid && (ent_r.stamp <= cmd.thr);

  assign link_o.ent   = ent_r;
  assign link_o.valid = valid_r;
  assign link_o.ahead = ahead;

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    unique case (cmd.op)
      ssc_pkg::OP_HOLD: begin
      end
      ssc_pkg::OP_INSERT: begin
        if (cmd.exists) begin
          if (match_o) begin
            ent_nxt.stamp  = cmd.ent.stamp;
            ent_nxt.handle = cmd.ent.handle;
          end
        end else if (ahead) begin
          ent_nxt = ent_r;
        end else if (prev_link.ahead) begin
          ent_nxt   = cmd.ent;
          valid_nxt = 1'b1;
        end else begin
          ent_nxt   = prev_link.ent;
          valid_nxt = prev_link.valid;
        end
      end
      ssc_pkg::OP_ROTATE: begin
        // valid prefix turns by one, the tail refills from the head
        if (valid_r) begin
          ent_nxt = next_link.valid ? next_link.ent : head_ent;
        end
      end
      ssc_pkg::OP_SHIFT: begin
        ent_nxt   = next_link.ent;
        valid_nxt = next_link.valid;
      end
      ssc_pkg::OP_TRIM: begin
        if (kill_o) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/ssc_ctrl.sv
// sequencer: handshakes, expiry register, count and cell commands
module ssc_ctrl #(
  parameter int CAPACITY = ssc_pkg::DEF_CAPACITY
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ssc_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ssc_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  ssc_pkg::chain_t chain,
  output ssc_pkg::cmd_t   cmd
);

  localparam int CW = $clog2(CAPACITY + 1);

  ssc_pkg::state_t state_r, state_nxt;
  ssc_pkg::in_t    op_r, op_nxt;
  ssc_pkg::out_t   res_r, res_nxt;
  ssc_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rot_cnt_r, rot_cnt_nxt;
  logic [31:0]     exp_r;
  logic [63:0]     thr_r, thr_cmb;
  logic            full;
  logic            found;

  // threshold from the highest-key entry, saturating at zero
  always_comb begin
    thr_cmb = 64'd0;
    if (chain.head_valid && (chain.head.stamp > 64'(exp_r))) begin
      thr_cmb = chain.head.stamp - 64'(exp_r);
    end
  end

  assign full      = (count_r == CW'(CAPACITY));
  assign found     = (res_r.status == ssc_pkg::ST_FOUND);
  assign in_stall  = (state_r != ssc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    count_nxt     = count_r;
    rot_cnt_nxt   = rot_cnt_r;
    cmd.op        = ssc_pkg::OP_HOLD;
    cmd.ent.key   = op_r.key;
    cmd.ent.stamp = op_r.stamp;
    cmd.ent.handle = op_r.handle;
    cmd.exists    = chain.any_match;
    cmd.thr       = thr_r;
    unique case (state_r)
      ssc_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data;
          res_nxt = '0;
          res_nxt.status = ssc_pkg::ST_NONE;
          state_nxt = ssc_pkg::S_EXEC;
        end
      end
      ssc_pkg::S_EXEC: begin
        unique case (op_r.kind)
          ssc_pkg::KIND_ADD: begin
            if (op_r.stamp <= thr_r) begin
              res_nxt.status = ssc_pkg::ST_EXPIRED;
              state_nxt      = ssc_pkg::S_DONE;
            end else if (!chain.any_match && full) begin
              res_nxt.status = ssc_pkg::ST_FULL;
              state_nxt      = ssc_pkg::S_DONE;
            end else begin
              cmd.op         = ssc_pkg::OP_INSERT;
              res_nxt.status = ssc_pkg::ST_STORED;
              if (!chain.any_match) begin
                count_nxt = count_r + CW'(1);
              end
              state_nxt = ssc_pkg::S_THR;
            end
          end
          ssc_pkg::KIND_LOOKUP: begin
            rot_cnt_nxt = '0;
            state_nxt   = (count_r == '0) ? ssc_pkg::S_DONE : ssc_pkg::S_ROT;
          end
          ssc_pkg::KIND_REORG: begin
            state_nxt = ssc_pkg::S_CUT;
          end
          default: begin
            state_nxt = ssc_pkg::S_DONE;
          end
        endcase
      end
      ssc_pkg::S_THR: begin
        // thr_r picks up the new head stamp on this edge
        state_nxt = ssc_pkg::S_TRIM;
      end
      ssc_pkg::S_TRIM: begin
        if (chain.any_kill) begin
          cmd.op    = ssc_pkg::OP_TRIM;
          count_nxt = count_r - CW'(1);
        end else begin
          state_nxt = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_ROT: begin
        cmd.op = ssc_pkg::OP_ROTATE;
        // keys pass the head in descending order, so the first hit is the floor
        if (!found && chain.head_valid && (chain.head.key <= op_r.key)) begin
          res_nxt.status       = ssc_pkg::ST_FOUND;
          res_nxt.found_key    = chain.head.key;
          res_nxt.found_stamp  = chain.head.stamp;
          res_nxt.found_handle = chain.head.handle;
        end
        rot_cnt_nxt = rot_cnt_r + CW'(1);
        if (rot_cnt_r == count_r - CW'(1)) begin
          state_nxt = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_CUT: begin
        if (chain.head_valid && (chain.head.key >= op_r.key)) begin
          cmd.op    = ssc_pkg::OP_SHIFT;
          count_nxt = count_r - CW'(1);
        end else begin
          state_nxt = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt             = res_r;
          out_nxt.entry_count = 5'(count_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = ssc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    rot_cnt_r <= rot_cnt_nxt;
    // frozen while trimming so the threshold is taken once per add
    if (state_r != ssc_pkg::S_TRIM) begin
      thr_r <= thr_cmb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      exp_r       <= ssc_pkg::EXPIRY_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      if (cfg_we) begin
        exp_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: hw/rtl/ssc_checker.sv
// port-level checks on the snapshot cache and their bind
`include "sorted_snapshot_cache_with_expiry_core_assert.svh"

module ssc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ssc_pkg::out_t out_data
);

  // one item in flight: a transfer closes the input until its result is out
  `SSC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  `SSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // found fields are zero for every status but found
  `SSC_ASSERT_NOW(a_found_clear, out_valid && (out_data.status != ssc_pkg::ST_FOUND), (out_data.found_key == 64'd0) && (out_data.found_stamp == 64'd0) && (out_data.found_handle == 32'd0))

  `SSC_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid && !in_stall)

endmodule

bind sorted_snapshot_cache_with_expiry_core ssc_checker u_ssc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
